// File: rtl/breakpoint_match_table_macros.svh
// Assertion shorthand for the breakpoint match table.
// Each check is sampled on the rising clock edge and is held off while reset is applied.
`ifndef BREAKPOINT_MATCH_TABLE_MACROS_SVH
`define BREAKPOINT_MATCH_TABLE_MACROS_SVH

`define BPMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define BPMT_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) trig |=> prop) else $error(msg);

`endif

// File: rtl/bpmt_pkg.sv
package bpmt_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned SlotW      = 4;
  localparam int unsigned CmpW       = (CntW > SlotW) ? CntW : SlotW;
  localparam int unsigned AddrW      = 16;
  localparam int unsigned KindW      = 2;

  typedef enum logic [2:0] {
    CmdAdd    = 3'd0,
    CmdRemove = 3'd1,
    CmdEnable = 3'd2,
    CmdCheck  = 3'd3,
    CmdClear  = 3'd4
  } cmd_e;

  localparam logic [KindW-1:0] KindAny = 2'd3;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [KindW-1:0] kind;
    logic             enabled;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic set_en;
    logic en_value;
    logic clear;
  } cell_ctrl_t;

endpackage

// File: rtl/bpmt_cell.sv
module bpmt_cell
  import bpmt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  entry_t           new_entry_i,
  input  entry_t           next_entry_i,
  input  logic [AddrW-1:0] probe_addr_i,
  input  logic [KindW-1:0] probe_kind_i,
  output entry_t           entry_o,
  output logic             match_o
);

  logic [AddrW-1:0] addr_q, addr_d;
  logic [KindW-1:0] kind_q, kind_d;
  logic             en_q, en_d;

  always_comb begin
    addr_d = addr_q;
    kind_d = kind_q;
    en_d   = en_q;
    if (ctrl_i.clear) begin
      en_d = 1'b0;
    end else if (ctrl_i.load) begin
      addr_d = new_entry_i.addr;
      kind_d = new_entry_i.kind;
      en_d   = new_entry_i.enabled;
    end else if (ctrl_i.shift) begin
      // Removal pulls the entry of the upper neighbour down into this cell.
      addr_d = next_entry_i.addr;
      kind_d = next_entry_i.kind;
      en_d   = next_entry_i.enabled;
    end else if (ctrl_i.set_en) begin
      en_d = ctrl_i.en_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else begin
      en_q <= en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    kind_q <= kind_d;
  end

  assign entry_o = '{addr: addr_q, kind: kind_q, enabled: en_q};
  assign match_o = en_q && (addr_q == probe_addr_i) &&
                   ((kind_q == probe_kind_i) || (kind_q == KindAny));

endmodule

// File: rtl/breakpoint_match_table.sv
// Breakpoint match table: a compact list of up to TableDepth breakpoints kept in a row of
// cells, slot 0 at the bottom. Every transaction (add, remove, set enable, check, clear)
// is handled in the cycle in which it is accepted, and its result is registered and
// shown in the next cycle; with the output not stalled a new transaction is taken every cycle.
// That figure is set by the cell row, which updates all cells at once: removal shifts every
// later cell down from its neighbour in that same cycle, and a check compares all cells in
// parallel and picks the lowest enabled match. No clearing pass is needed after reset.
`include "breakpoint_match_table_macros.svh"

module breakpoint_match_table
  import bpmt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       command_i,
  input  logic [1:0]       access_type_i,
  input  logic [15:0]      address_i,
  input  logic [3:0]       slot_i,
  input  logic             enable_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             status_o,
  output logic             hit_o,
  output logic [3:0]       hit_slot_o,
  output logic [3:0]       new_slot_o,
  output logic [4:0]       entry_count_o
);

  logic            accept;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic            status_q, status_d;
  logic            hit_q, hit_d;
  logic [3:0]      hit_slot_q, hit_slot_d;
  logic [3:0]      new_slot_q, new_slot_d;
  logic [4:0]      entry_count_q;

  logic [CmpW-1:0] count_ext;
  logic [CmpW-1:0] slot_ext;
  logic            slot_ok;
  logic            is_add_ok;
  logic            is_remove_ok;
  logic            is_enable_ok;
  logic            is_clear;

  cell_ctrl_t             ctrl  [TableDepth];
  entry_t                 entry [TableDepth];
  logic [TableDepth-1:0]  match;
  logic [TableDepth-1:0]  live;
  entry_t                 new_entry;
  logic                   any_hit;
  logic [IdxW-1:0]        hit_idx;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign count_ext = CmpW'(count_q);
  assign slot_ext  = CmpW'(slot_i);
  assign slot_ok   = slot_ext < count_ext;

  assign is_add_ok    = accept && (command_i == CmdAdd) && (count_ext < CmpW'(TableDepth));
  assign is_remove_ok = accept && (command_i == CmdRemove) && slot_ok;
  assign is_enable_ok = accept && (command_i == CmdEnable) && slot_ok;
  assign is_clear     = accept && (command_i == CmdClear);

  assign new_entry = '{addr: address_i, kind: access_type_i, enabled: 1'b1};

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    entry_t next_entry;

    if (i == TableDepth - 1) begin : g_top
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = entry[i+1];
    end

    assign ctrl[i].load     = is_add_ok && (count_ext == CmpW'(i));
    assign ctrl[i].shift    = is_remove_ok && (CmpW'(i) >= slot_ext);
    assign ctrl[i].set_en   = is_enable_ok && (CmpW'(i) == slot_ext);
    assign ctrl[i].en_value = enable_value_i;
    assign ctrl[i].clear    = is_clear;
    assign live[i]          = CmpW'(i) < count_ext;

    bpmt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl[i]),
      .new_entry_i  (new_entry),
      .next_entry_i (next_entry),
      .probe_addr_i (address_i),
      .probe_kind_i (access_type_i),
      .entry_o      (entry[i]),
      .match_o      (match[i])
    );
  end

  // Lowest live enabled match wins, so scan from the top and let lower slots overwrite.
  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (match[i] && live[i]) begin
        any_hit = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    count_d    = count_q;
    status_d   = 1'b0;
    hit_d      = 1'b0;
    hit_slot_d = '0;
    new_slot_d = '0;
    case (command_i)
      CmdAdd: begin
        if (is_add_ok) begin
          new_slot_d = 4'(count_q);
          count_d    = count_q + CntW'(1);
        end else begin
          status_d = 1'b1;
        end
      end
      CmdRemove: begin
        if (is_remove_ok) begin
          count_d = count_q - CntW'(1);
        end else begin
          status_d = 1'b1;
        end
      end
      CmdEnable: begin
        status_d = !slot_ok;
      end
      CmdCheck: begin
        hit_d      = any_hit;
        hit_slot_d = any_hit ? 4'(hit_idx) : 4'd0;
      end
      CmdClear: begin
        count_d = '0;
      end
      default: begin
        status_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q      <= status_d;
      hit_q         <= hit_d;
      hit_slot_q    <= hit_slot_d;
      new_slot_q    <= new_slot_d;
      entry_count_q <= 5'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign hit_o         = hit_q;
  assign hit_slot_o    = hit_slot_q;
  assign new_slot_o    = new_slot_q;
  assign entry_count_o = entry_count_q;

  `BPMT_ASSERT(a_count_bound, count_ext <= CmpW'(TableDepth), "entry count beyond table depth")
  `BPMT_ASSERT_NEXT(a_add_grows, is_add_ok, count_q == $past(count_q) + CntW'(1), "add did not grow the table")
  `BPMT_ASSERT_NEXT(a_result_follows, accept, out_valid_q, "accepted transaction gave no result")
  `BPMT_ASSERT(a_hit_ok, out_valid_q && hit_q |-> !status_q && (new_slot_q == 4'd0), "hit reported with error or slot")

endmodule

// File: sim/bpmt_checker.sv
`timescale 1ns / 100ps

module bpmt_checker
  import bpmt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  command_i,
  input  logic [1:0]  access_type_i,
  input  logic [15:0] address_i,
  input  logic [3:0]  slot_i,
  input  logic        enable_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        status_i,
  input  logic        hit_i,
  input  logic [3:0]  hit_slot_i,
  input  logic [3:0]  new_slot_i,
  input  logic [4:0]  entry_count_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic       status;
    logic       hit;
    logic [3:0] hit_slot;
    logic [3:0] new_slot;
    logic [4:0] entry_count;
  } bp_result_t;

  logic [AddrW-1:0] bp_addr [TableDepth];
  logic [KindW-1:0] bp_kind [TableDepth];
  logic             bp_on   [TableDepth];
  int unsigned      bp_used;
  bp_result_t       awaited_results [$];
  bp_result_t       oldest_result;

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count_o++;
  endtask

  // Applies one transaction to the shadow table and returns the result it should give.
  function automatic bp_result_t apply_command(logic [2:0] cmd, logic [1:0] kind,
                                               logic [15:0] addr, logic [3:0] slot,
                                               logic en);
    bp_result_t  res;
    int unsigned i;
    res = '0;
    case (cmd)
      CmdAdd: begin
        if (bp_used >= TableDepth) begin
          res.status = 1'b1;
        end else begin
          bp_addr[bp_used] = addr;
          bp_kind[bp_used] = kind;
          bp_on[bp_used]   = 1'b1;
          res.new_slot     = 4'(bp_used);
          bp_used++;
        end
      end
      CmdRemove: begin
        if (slot >= bp_used) begin
          res.status = 1'b1;
        end else begin
          for (i = slot; i + 1 < bp_used; i++) begin
            bp_addr[i] = bp_addr[i+1];
            bp_kind[i] = bp_kind[i+1];
            bp_on[i]   = bp_on[i+1];
          end
          bp_used--;
        end
      end
      CmdEnable: begin
        if (slot >= bp_used) begin
          res.status = 1'b1;
        end else begin
          bp_on[slot] = en;
        end
      end
      CmdCheck: begin
        // The first match found walking up from slot 0 is the lowest one.
        for (i = 0; i < bp_used; i++) begin
          if (!res.hit && bp_on[i] && bp_addr[i] == addr &&
              (bp_kind[i] == kind || bp_kind[i] == KindAny)) begin
            res.hit      = 1'b1;
            res.hit_slot = 4'(i);
          end
        end
      end
      CmdClear: begin
        bp_used = 0;
        for (i = 0; i < TableDepth; i++) bp_on[i] = 1'b0;
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
    res.entry_count = 5'(bp_used);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_used = 0;
      for (int k = 0; k < TableDepth; k++) bp_on[k] = 1'b0;
      awaited_results.delete();
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(apply_command(command_i, access_type_i, address_i,
                                                slot_i, enable_value_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result transaction with nothing outstanding");
        end else begin
          oldest_result = awaited_results.pop_front();
          if (status_i !== oldest_result.status)
            report_mismatch($sformatf("status: got %0d, expected %0d",
                                      status_i, oldest_result.status));
          if (hit_i !== oldest_result.hit)
            report_mismatch($sformatf("hit: got %0d, expected %0d",
                                      hit_i, oldest_result.hit));
          if (hit_slot_i !== oldest_result.hit_slot)
            report_mismatch($sformatf("hit_slot: got %0d, expected %0d",
                                      hit_slot_i, oldest_result.hit_slot));
          if (new_slot_i !== oldest_result.new_slot)
            report_mismatch($sformatf("new_slot: got %0d, expected %0d",
                                      new_slot_i, oldest_result.new_slot));
          if (entry_count_i !== oldest_result.entry_count)
            report_mismatch($sformatf("entry_count: got %0d, expected %0d",
                                      entry_count_i, oldest_result.entry_count));
        end
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import bpmt_pkg::*;

  localparam logic [2:0] CmdSpareFirst = 3'd5;
  localparam logic [2:0] CmdSpareLast  = 3'd7;
  localparam logic [1:0] KindExec      = 2'd0;
  localparam logic [1:0] KindRead      = 2'd1;
  localparam logic [1:0] KindWrite     = 2'd2;
  localparam int         WatchdogLimit = 1000;
  localparam int         HoldOffCycles = 60;
  localparam int         PhaseItems    = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  command_i;
  logic [1:0]  access_type_i;
  logic [15:0] address_i;
  logic [3:0]  slot_i;
  logic        enable_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        status_o;
  logic        hit_o;
  logic [3:0]  hit_slot_o;
  logic [3:0]  new_slot_o;
  logic [4:0]  entry_count_o;

  int          mismatches;
  int          pending;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          fill_est;
  int          hold_left;
  int          idle_cycles;
  logic        hold_request;
  logic [15:0] hot_addr [8];

  breakpoint_match_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .access_type_i (access_type_i),
    .address_i     (address_i),
    .slot_i        (slot_i),
    .enable_value_i(enable_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .hit_o         (hit_o),
    .hit_slot_o    (hit_slot_o),
    .new_slot_o    (new_slot_o),
    .entry_count_o (entry_count_o)
  );

  bpmt_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .command_i       (command_i),
    .access_type_i   (access_type_i),
    .address_i       (address_i),
    .slot_i          (slot_i),
    .enable_value_i  (enable_value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_i        (status_o),
    .hit_i           (hit_o),
    .hit_slot_i      (hit_slot_o),
    .new_slot_i      (new_slot_o),
    .entry_count_i   (entry_count_o),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Result side: random stalls, or a long hold-off once one has been requested.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HoldOffCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("breakpoint_match_table: mismatch");
        $finish;
      end
    end
  end

  // Offers one command transaction and returns at the falling edge after it is taken.
  task automatic send_op(logic [2:0] cmd, logic [1:0] kind, logic [15:0] addr,
                         logic [3:0] slot, logic en);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    access_type_i  <= kind;
    address_i      <= addr;
    slot_i         <= slot;
    enable_value_i <= en;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    // A rough fill level, only used to steer slot numbers towards live entries.
    case (cmd)
      CmdAdd:    if (fill_est < TableDepth) fill_est++;
      CmdRemove: if (slot < fill_est) fill_est--;
      CmdClear:  fill_est = 0;
      default:   ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic send_random_op();
    int          pick;
    logic [15:0] addr;
    logic [3:0]  slot;
    logic [1:0]  kind;
    pick = $urandom_range(99);
    kind = 2'($urandom_range(3));
    addr = ($urandom_range(99) < 85) ? hot_addr[$urandom_range(7)] : 16'($urandom);
    if (fill_est > 0 && $urandom_range(99) < 80)
      slot = 4'($urandom_range(fill_est - 1));
    else
      slot = 4'($urandom_range(15));
    if (pick < 35)
      send_op(CmdAdd, kind, addr, slot, 1'($urandom));
    else if (pick < 50)
      send_op(CmdRemove, kind, addr, slot, 1'($urandom));
    else if (pick < 60)
      send_op(CmdEnable, kind, addr, slot, 1'($urandom));
    else if (pick < 90)
      send_op(CmdCheck, kind, addr, slot, 1'($urandom));
    else if (pick < 93)
      send_op(CmdClear, kind, addr, slot, 1'($urandom));
    else if (pick < 96)
      send_op(3'($urandom_range(CmdSpareLast, CmdSpareFirst)), kind, addr, slot,
              1'($urandom));
    else
      send_op(3'($urandom), kind, 16'($urandom), 4'($urandom), 1'($urandom));
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = CmdCheck;
    access_type_i  = KindExec;
    address_i      = '0;
    slot_i         = '0;
    enable_value_i = 1'b0;
    out_stall_i    = 1'b0;
    hold_request   = 1'b0;
    hold_left      = 0;
    fill_est       = 0;
    send_idle_pct  = 9;
    recv_stall_pct = 79;
    hot_addr[0]    = 16'h0000;
    hot_addr[1]    = 16'hFFFF;
    for (int k = 2; k < 8; k++) hot_addr[k] = 16'($urandom);
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty table: nothing to hit, every slot out of range.
    send_op(CmdCheck, KindAny, 16'hFFFF, 4'd0, 1'b0);
    send_op(CmdRemove, KindExec, 16'h0000, 4'd0, 1'b0);
    send_op(CmdEnable, KindExec, 16'h0000, 4'd15, 1'b1);
    send_op(CmdAdd, KindExec, 16'h0000, 4'd0, 1'b0);
    send_op(CmdAdd, KindAny, 16'hFFFF, 4'd15, 1'b1);
    send_op(CmdAdd, KindRead, 16'h1234, 4'd0, 1'b0);
    send_op(CmdAdd, KindWrite, 16'h1234, 4'd0, 1'b0);
    // An any-access entry matches every access type, but an any-access check only
    // matches entries of that same type.
    send_op(CmdCheck, KindExec, 16'hFFFF, 4'd0, 1'b0);
    send_op(CmdCheck, KindWrite, 16'h1234, 4'd0, 1'b0);
    send_op(CmdCheck, KindAny, 16'h1234, 4'd0, 1'b0);
    send_op(CmdCheck, KindRead, 16'h0000, 4'd0, 1'b0);
    send_op(CmdEnable, KindExec, 16'h0000, 4'd1, 1'b0);
    send_op(CmdCheck, KindRead, 16'hFFFF, 4'd0, 1'b0);
    send_op(CmdEnable, KindExec, 16'h0000, 4'd1, 1'b1);
    send_op(CmdRemove, KindExec, 16'h0000, 4'd0, 1'b0);
    send_op(CmdCheck, KindWrite, 16'hFFFF, 4'd0, 1'b0);
    send_op(CmdRemove, KindExec, 16'h0000, 4'd3, 1'b0);
    send_op(CmdSpareFirst, KindExec, 16'hFFFF, 4'd0, 1'b0);
    send_op(3'd6, KindAny, 16'h1234, 4'd1, 1'b1);
    send_op(CmdSpareLast, KindRead, 16'h0000, 4'd15, 1'b1);
    send_op(CmdClear, KindExec, 16'h0000, 4'd0, 1'b0);
    send_op(CmdCheck, KindRead, 16'h1234, 4'd0, 1'b0);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 9 : (phase == 1) ? 79 : 0;
      recv_stall_pct = (phase == 0) ? 79 : (phase == 1) ? 9 : 0;
      for (int n = 0; n < PhaseItems; n++) begin
        if (n == PhaseItems / 3) hold_request = 1'b1;
        send_random_op();
      end
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("breakpoint_match_table: match");
    end else begin
      $display("breakpoint_match_table: mismatch");
    end
    $finish;
  end

endmodule
